/* src/cv3_pkg.sv */
`timescale 1ns / 1ps

package cv3_pkg;

    // Frame geometry limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;

    // Pixel and arithmetic widths.
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int ACC_W  = 13;
    localparam int MAG_W  = ACC_W - 1;

    // Reciprocals for exact truncating division of values below 4096.
    localparam int RECIP_SHIFT = 15;
    localparam int RECIP_NINE  = 3641;
    localparam int RECIP_THREE = 10923;
    localparam int MULT_W      = 14;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_KERNEL = 2'd2,
        CFG_GRAY   = 2'd3
    } t_cfg_index;

    // Kernel codes; codes above pass-through also pass pixels through.
    typedef enum logic [2:0] {
        K_SMOOTH  = 3'd0,
        K_BLUR    = 3'd1,
        K_SHARPEN = 3'd2,
        K_MEAN    = 3'd3,
        K_EMBOSS  = 3'd4,
        K_PASS    = 3'd5
    } t_kernel;

    // One column of the 3x3 window: upper, middle and lower row.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    // Per-request bookkeeping carried along the pipeline.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] col;
        logic              emit_win;
        logic              emit_upper;
        logic              emit_cur;
        logic              frame_end;
        logic              interior;
    } t_meta;

endpackage

/* src/cv3_line_mem.sv */
`timescale 1ns / 1ps

module cv3_line_mem (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [cv3_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [cv3_pkg::PIX_W-1:0]  o_rd_data,
    input  logic                       i_wr_en,
    input  logic [cv3_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [cv3_pkg::PIX_W-1:0]  i_wr_data
);
    import cv3_pkg::*;

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/cv3_cell.sv */
`timescale 1ns / 1ps

module cv3_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  cv3_pkg::t_column i_col,
    output cv3_pkg::t_column o_col
);
    import cv3_pkg::*;

    t_column r_col;

    // Take the column from the right-hand neighbor on every shift.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

/* src/cv3_chan_acc.sv */
`timescale 1ns / 1ps

module cv3_chan_acc (
    input  cv3_pkg::t_kernel                   i_kernel,
    input  logic [8:0][cv3_pkg::CH_W-1:0]      i_win,
    output logic signed [cv3_pkg::ACC_W-1:0]   o_acc
);
    import cv3_pkg::*;

    logic signed [ACC_W-1:0] s_v [9];
    logic signed [ACC_W-1:0] s_corners;
    logic signed [ACC_W-1:0] s_edges;
    logic signed [ACC_W-1:0] s_sum9;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            s_v[i] = ACC_W'($unsigned(i_win[i]));
        end
    end

    // Shared partial sums of the window.
    assign s_corners = s_v[0] + s_v[2] + s_v[6] + s_v[8];
    assign s_edges   = s_v[1] + s_v[3] + s_v[5] + s_v[7];
    assign s_sum9    = s_corners + s_edges + s_v[4];

    // Kernel weighting before the divide.
    always_comb begin
        case (i_kernel)
            K_SMOOTH:  o_acc = s_sum9;
            K_BLUR:    o_acc = s_corners + (s_edges <<< 1) + (s_v[4] <<< 2);
            K_SHARPEN: o_acc = (s_v[4] <<< 3) + (s_v[4] <<< 1) + s_v[4] - (s_edges <<< 1);
            K_MEAN:    o_acc = (s_v[4] <<< 3) + (s_v[4] <<< 1) - s_sum9;
            K_EMBOSS:  o_acc = s_v[1] - s_v[7];
            default:   o_acc = s_v[4];
        endcase
    end

endmodule

/* src/cv3_chan_div.sv */
`timescale 1ns / 1ps

module cv3_chan_div (
    input  cv3_pkg::t_kernel                 i_kernel,
    input  logic signed [cv3_pkg::ACC_W-1:0] i_acc,
    output logic [cv3_pkg::CH_W-1:0]         o_val
);
    import cv3_pkg::*;

    localparam int PROD_W = MAG_W + MULT_W;

    logic [MAG_W-1:0]  s_mag;
    logic [MULT_W-1:0] s_recip;
    logic [PROD_W-1:0] s_prod;
    logic [MAG_W-1:0]  s_quot;

    assign s_mag   = i_acc[MAG_W-1:0];
    assign s_recip = (i_kernel == K_SHARPEN) ? MULT_W'(RECIP_THREE) : MULT_W'(RECIP_NINE);
    assign s_prod  = PROD_W'(s_mag) * PROD_W'(s_recip);

    // Divide by 9, 16 or 3 (exact for non-negative sums), or by 1.
    always_comb begin
        case (i_kernel) inside
            K_SMOOTH, K_SHARPEN: s_quot = MAG_W'(s_prod[PROD_W-1:RECIP_SHIFT]);
            K_BLUR:              s_quot = s_mag >> 4;
            default:             s_quot = s_mag;
        endcase
    end

    // Negative results clamp to zero, large ones to full scale.
    always_comb begin
        if (i_acc < 0) begin
            o_val = '0;
        end else if (s_quot > MAG_W'(255)) begin
            o_val = '1;
        end else begin
            o_val = s_quot[CH_W-1:0];
        end
    end

endmodule

/* src/conv3x3_kernel_filter_unit.sv */
`timescale 1ns / 1ps

// A pixel request passes through the stage 1, 2 and 3 registers into the output register.
// Throughput: one pixel per cycle while i_ready is high; a pixel closing a row or in
// the last row causes up to three results, which leave one per cycle through the output
// buffer, so under a steady stream each extra result holds the input back.
// Reset clears the row and column counters, all pipeline valids and the registers
// (width and height 1024, pass-through, color); line stores and window are not cleared.
module conv3x3_kernel_filter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cv3_pkg::CH_W-1:0]    i_pix_red,
    input  logic [cv3_pkg::CH_W-1:0]    i_pix_green,
    input  logic [cv3_pkg::CH_W-1:0]    i_pix_blue,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [cv3_pkg::SIZE_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cv3_pkg::ROW_W-1:0]   o_out_row,
    output logic [cv3_pkg::ADDR_W-1:0]  o_out_col,
    output logic [cv3_pkg::CH_W-1:0]    o_out_red,
    output logic [cv3_pkg::CH_W-1:0]    o_out_green,
    output logic [cv3_pkg::CH_W-1:0]    o_out_blue,
    output logic                        o_last_out,
    output logic                        o_frame_done
);
    import cv3_pkg::*;

    // Configuration registers.
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    t_kernel           r_kernel;
    logic              r_gray;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(MAX_WIDTH);
            r_height <= SIZE_W'(MAX_HEIGHT);
            r_kernel <= K_PASS;
            r_gray   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_KERNEL: r_kernel <= t_kernel'(i_cfg_data[2:0]);
                CFG_GRAY:   r_gray   <= i_cfg_data[0];
                default:    r_gray   <= r_gray;
            endcase
        end
    end

    // Effective frame size saturated to 1..max.
    logic [SIZE_W-1:0] s_w;
    logic [SIZE_W-1:0] s_h;

    always_comb begin
        if (r_width == '0) begin
            s_w = SIZE_W'(1);
        end else if (r_width > SIZE_W'(MAX_WIDTH)) begin
            s_w = SIZE_W'(MAX_WIDTH);
        end else begin
            s_w = r_width;
        end
        if (r_height == '0) begin
            s_h = SIZE_W'(1);
        end else if (r_height > SIZE_W'(MAX_HEIGHT)) begin
            s_h = SIZE_W'(MAX_HEIGHT);
        end else begin
            s_h = r_height;
        end
    end

    // Pipeline valids and handshakes.
    logic r_v1, r_v2, r_v3;
    logic [2:0] r_mask;
    logic s_out_take, s_single, s_s4_free;
    logic s_s3_go, s_s3_rdy, s_s2_go, s_s2_rdy, s_s1_go, s_s1_rdy, s_accept;

    assign s_single   = ((r_mask & (r_mask - 3'd1)) == 3'd0);
    assign o_valid    = (r_mask != 3'd0);
    assign s_out_take = o_valid && i_ready;
    assign s_s4_free  = !o_valid || (s_out_take && s_single);
    assign s_s3_go    = r_v3 && s_s4_free;
    assign s_s3_rdy   = !r_v3 || s_s4_free;
    assign s_s2_go    = r_v2 && s_s3_rdy;
    assign s_s2_rdy   = !r_v2 || s_s3_rdy;
    assign s_s1_go    = r_v1 && s_s2_rdy;
    assign s_s1_rdy   = !r_v1 || s_s2_rdy;
    assign o_ready    = s_s1_rdy;
    assign s_accept   = i_valid && s_s1_rdy;

    // Raster counters and per-pixel result flags.
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_col;
    logic s_end_row, s_last_row;
    t_meta s_meta;

    assign s_end_row  = (SIZE_W'(r_col) + SIZE_W'(1)) >= s_w;
    assign s_last_row = (SIZE_W'(r_row) + SIZE_W'(1)) >= s_h;

    always_comb begin
        s_meta.row        = r_row;
        s_meta.col        = r_col;
        s_meta.emit_win   = (r_row != '0) && (r_col != '0);
        s_meta.emit_upper = (r_row != '0) && s_end_row;
        s_meta.emit_cur   = s_last_row;
        s_meta.frame_end  = s_end_row && s_last_row;
        s_meta.interior   = (r_row >= ROW_W'(2)) && (SIZE_W'(r_row) + SIZE_W'(1) <= s_h)
                         && (r_col >= ADDR_W'(2)) && (SIZE_W'(r_col) + SIZE_W'(1) <= s_w)
                         && (r_kernel < K_PASS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (s_accept) begin
            if (s_end_row) begin
                r_col <= '0;
                r_row <= s_last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + ADDR_W'(1);
            end
        end
    end

    // Stage 1: line store reads, with forwarding of the write at the same edge.
    t_meta            r_m1;
    logic [PIX_W-1:0] r_px1;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_up, r_fwd_lo;
    logic [PIX_W-1:0] s_up_rd, s_lo_rd, s_up1, s_lo1;

    cv3_line_mem u_upper (
        .i_clk     (i_clk),
        .i_rd_en   (s_accept),
        .i_rd_addr (r_col),
        .o_rd_data (s_up_rd),
        .i_wr_en   (s_s1_go),
        .i_wr_addr (r_m1.col),
        .i_wr_data (s_lo1)
    );

    cv3_line_mem u_lower (
        .i_clk     (i_clk),
        .i_rd_en   (s_accept),
        .i_rd_addr (r_col),
        .o_rd_data (s_lo_rd),
        .i_wr_en   (s_s1_go),
        .i_wr_addr (r_m1.col),
        .i_wr_data (r_px1)
    );

    assign s_up1 = r_fwd ? r_fwd_up : s_up_rd;
    assign s_lo1 = r_fwd ? r_fwd_lo : s_lo_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_s1_rdy) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m1     <= s_meta;
            r_px1    <= {i_pix_red, i_pix_green, i_pix_blue};
            r_fwd    <= s_s1_go && (r_m1.col == r_col);
            r_fwd_up <= s_lo1;
            r_fwd_lo <= r_px1;
        end
    end

    // Window: a chain of three column cells shifting right to left.
    t_column s_new_col, s_col0, s_col1, s_col2;

    assign s_new_col = '{top: s_up1, mid: s_lo1, bot: r_px1};

    cv3_cell u_cell2 (.i_clk(i_clk), .i_shift(s_s1_go), .i_col(s_new_col), .o_col(s_col2));
    cv3_cell u_cell1 (.i_clk(i_clk), .i_shift(s_s1_go), .i_col(s_col2),    .o_col(s_col1));
    cv3_cell u_cell0 (.i_clk(i_clk), .i_shift(s_s1_go), .i_col(s_col1),    .o_col(s_col0));

    // Stage 2: window in place, results of the border paths kept alongside.
    t_meta            r_m2;
    logic [PIX_W-1:0] r_lo2, r_px2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s_s2_rdy) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_s1_go) begin
            r_m2  <= r_m1;
            r_lo2 <= s_lo1;
            r_px2 <= r_px1;
        end
    end

    // Per-channel weighted sums from the window.
    logic signed [ACC_W-1:0] s_acc [3];

    for (genvar g = 0; g < 3; g++) begin : g_acc
        localparam int LSB = (2 - g) * CH_W;
        logic [8:0][CH_W-1:0] s_win;
        assign s_win[0] = s_col0.top[LSB +: CH_W];
        assign s_win[1] = s_col1.top[LSB +: CH_W];
        assign s_win[2] = s_col2.top[LSB +: CH_W];
        assign s_win[3] = s_col0.mid[LSB +: CH_W];
        assign s_win[4] = s_col1.mid[LSB +: CH_W];
        assign s_win[5] = s_col2.mid[LSB +: CH_W];
        assign s_win[6] = s_col0.bot[LSB +: CH_W];
        assign s_win[7] = s_col1.bot[LSB +: CH_W];
        assign s_win[8] = s_col2.bot[LSB +: CH_W];
        cv3_chan_acc u_acc (.i_kernel(r_kernel), .i_win(s_win), .o_acc(s_acc[g]));
    end

    // Stage 3: sums registered.
    t_meta                   r_m3;
    logic [PIX_W-1:0]        r_lo3, r_px3, r_ctr3;
    logic signed [ACC_W-1:0] r_acc3 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (s_s3_rdy) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_s2_go) begin
            r_m3   <= r_m2;
            r_lo3  <= r_lo2;
            r_px3  <= r_px2;
            r_ctr3 <= s_col1.mid;
            for (int i = 0; i < 3; i++) begin
                r_acc3[i] <= s_acc[i];
            end
        end
    end

    // Divide and clamp per channel.
    logic [CH_W-1:0] s_q [3];

    for (genvar g = 0; g < 3; g++) begin : g_div
        cv3_chan_div u_div (.i_kernel(r_kernel), .i_acc(r_acc3[g]), .o_val(s_q[g]));
    end

    // Stage 4: output buffer emitting up to three results in order.
    t_meta            r_m4;
    logic [PIX_W-1:0] r_win4, r_lo4, r_px4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 3'd0;
        end else if (s_s3_go) begin
            r_mask <= {r_m3.emit_cur, r_m3.emit_upper, r_m3.emit_win};
        end else if (s_out_take) begin
            r_mask <= r_mask & (r_mask - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_s3_go) begin
            r_m4   <= r_m3;
            r_win4 <= r_m3.interior ? {s_q[0], s_q[1], s_q[2]} : r_ctr3;
            r_lo4  <= r_lo3;
            r_px4  <= r_px3;
        end
    end

    // Select the oldest pending result.
    logic [PIX_W-1:0] s_out_pix;

    always_comb begin
        if (r_mask[0]) begin
            o_out_row = r_m4.row - ROW_W'(1);
            o_out_col = r_m4.col - ADDR_W'(1);
            s_out_pix = r_win4;
        end else if (r_mask[1]) begin
            o_out_row = r_m4.row - ROW_W'(1);
            o_out_col = r_m4.col;
            s_out_pix = r_lo4;
        end else begin
            o_out_row = r_m4.row;
            o_out_col = r_m4.col;
            s_out_pix = r_px4;
        end
    end

    assign o_out_red    = s_out_pix[2*CH_W +: CH_W];
    assign o_out_green  = r_gray ? '0 : s_out_pix[CH_W +: CH_W];
    assign o_out_blue   = r_gray ? '0 : s_out_pix[0 +: CH_W];
    assign o_last_out   = s_single;
    assign o_frame_done = s_single && r_m4.frame_end;

endmodule
